// ===== rtl/skvt_pkg.sv =====
// Shared types and constants of the key/value table.
`default_nettype none

package skvt_pkg;

    localparam int KEY_BITS = 32;
    localparam int DATA_BITS = 32;

    // Command codes.
    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_MISSING = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_ACT,
        ST_VWAIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/small_key_value_table_core.sv =====
// Top level of the fixed-capacity key/value table.
// Sequence: the scan walks the key memory, a finish state compares the last entry, then the
// command acts; a get that hits also waits in a state for the value memory before it reports.
// A new transaction is taken only in idle, after the last one is through; the key scan covers
// one entry per cycle, and the done strobe lasts one cycle and the receiver cannot stall it.
// Reset clears every valid mark at once; key and value memories are not cleared.
`default_nettype none

module small_key_value_table_core #(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] key,
    input  wire logic [31:0] value,
    output logic             done,
    output logic      [1:0]  status,
    output logic             found,
    output logic      [31:0] read_value
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Transaction registers, captured when a command is accepted.
    skvt_pkg::state_t state_reg, state_next;
    logic [1:0]                         cmd_reg;
    logic [skvt_pkg::KEY_BITS-1:0]      key_reg;
    logic [skvt_pkg::DATA_BITS-1:0]     value_reg;

    // Scan address and the entry being compared in the following cycle, when the
    // key memory's read data arrives.
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_en_reg;

    // Valid marks live in flip-flops so that reset clears them in one step.
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // Result registers.
    logic        done_reg, done_next;
    logic [1:0]  status_reg, status_next;
    logic        found_reg, found_next;
    logic [31:0] read_value_reg, read_value_next;

    // Memory controls.
    logic                          key_we;
    logic [IDX_W-1:0]              key_waddr;
    logic [skvt_pkg::KEY_BITS-1:0] key_rdata;
    logic                          val_we;
    logic [IDX_W-1:0]              val_waddr;
    logic [VALUE_BITS-1:0]         val_wdata;
    logic [VALUE_BITS-1:0]         val_rdata;
    logic [31:0]                   val_rd32;

    // Scan results.
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;

    logic accept;

    assign accept = start && (state_reg == skvt_pkg::ST_IDLE);

    // Stored values are VALUE_BITS wide; the data port is 32 bits. Narrow
    // tables keep the low bits, wide tables zero-extend, and a read returns
    // the low 32 bits of a wide stored value and zero-extends a narrow one.
    generate
        if (VALUE_BITS == 32)
        begin : g_vw_eq
            assign val_wdata = value_reg;
            assign val_rd32  = val_rdata;
        end
        else if (VALUE_BITS > 32)
        begin : g_vw_gt
            assign val_wdata = {{(VALUE_BITS - 32){1'b0}}, value_reg};
            assign val_rd32  = val_rdata[31:0];
        end
        else
        begin : g_vw_lt
            assign val_wdata = value_reg[VALUE_BITS-1:0];
            assign val_rd32  = {{(32 - VALUE_BITS){1'b0}}, val_rdata};
        end
    endgenerate

    skvt_ram #(
        .WIDTH (skvt_pkg::KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (key_rdata)
    );

    // The value memory is read at the hit slot; its data is used only for a get that hit.
    skvt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (hit_idx),
        .rdata (val_rdata)
    );

    skvt_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .cmp_en    (cmp_en_reg),
        .cmp_idx   (cmp_idx_reg),
        .valid_bit (valid_reg[cmp_idx_reg]),
        .rd_key    (key_rdata),
        .key       (key_reg),
        .hit       (hit),
        .hit_idx   (hit_idx),
        .free      (free),
        .free_idx  (free_idx)
    );

    // Next state: the scan walks all entries, the finish state compares the
    // last one, then the command acts on the collected hit and free slot.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = skvt_pkg::ST_SCAN;
                end
            end
            skvt_pkg::ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = skvt_pkg::ST_FINISH;
                end
            end
            skvt_pkg::ST_FINISH:
            begin
                state_next = skvt_pkg::ST_ACT;
            end
            skvt_pkg::ST_ACT:
            begin
                if ((cmd_reg == skvt_pkg::CMD_GET) && hit)
                begin
                    state_next = skvt_pkg::ST_VWAIT;
                end
                else
                begin
                    state_next = skvt_pkg::ST_IDLE;
                end
            end
            skvt_pkg::ST_VWAIT:
            begin
                state_next = skvt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = skvt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: memory writes, valid updates and the result of each transaction.
    always_comb
    begin
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        key_we          = 1'b0;
        key_waddr       = free_idx;
        val_we          = 1'b0;
        val_waddr       = hit_idx;
        done_next       = 1'b0;
        status_next     = status_reg;
        found_next      = found_reg;
        read_value_next = read_value_reg;
        case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                idx_next = '0;
            end
            skvt_pkg::ST_SCAN:
            begin
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            skvt_pkg::ST_ACT:
            begin
                found_next      = hit;
                read_value_next = '0;
                status_next     = hit ? skvt_pkg::STATUS_OK : skvt_pkg::STATUS_MISSING;
                done_next       = 1'b1;
                case (cmd_reg)
                    skvt_pkg::CMD_SET:
                    begin
                        if (hit)
                        begin
                            val_we = 1'b1;
                        end
                        else if (free)
                        begin
                            key_we               = 1'b1;
                            val_we               = 1'b1;
                            val_waddr            = free_idx;
                            valid_next[free_idx] = 1'b1;
                            status_next          = skvt_pkg::STATUS_OK;
                        end
                        else
                        begin
                            status_next = skvt_pkg::STATUS_FULL;
                        end
                    end
                    skvt_pkg::CMD_GET:
                    begin
                        // A hit waits in the value-wait state for the value memory.
                        done_next = !hit;
                    end
                    skvt_pkg::CMD_REMOVE:
                    begin
                        if (hit)
                        begin
                            valid_next[hit_idx] = 1'b0;
                        end
                    end
                    default:
                    begin
                        // The unused command code only reports presence.
                    end
                endcase
            end
            skvt_pkg::ST_VWAIT:
            begin
                read_value_next = val_rd32;
                done_next       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= skvt_pkg::ST_IDLE;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
            cmp_en_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            cmp_en_reg <= (state_reg == skvt_pkg::ST_SCAN);
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            key_reg   <= key;
            value_reg <= value;
        end
        cmp_idx_reg    <= idx_reg;
        status_reg     <= status_next;
        found_reg      <= found_next;
        read_value_reg <= read_value_next;
    end

    assign busy       = (state_reg != skvt_pkg::ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;

endmodule

`default_nettype wire

// ===== rtl/skvt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module skvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/skvt_scan.sv =====
// Match and free-slot tracker that evaluates one table entry per cycle.
`default_nettype none

module skvt_scan #(
    parameter int IDX_W = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          cmp_en,
    input  wire logic [IDX_W-1:0]              cmp_idx,
    input  wire logic                          valid_bit,
    input  wire logic [skvt_pkg::KEY_BITS-1:0] rd_key,
    input  wire logic [skvt_pkg::KEY_BITS-1:0] key,
    output logic                               hit,
    output logic      [IDX_W-1:0]              hit_idx,
    output logic                               free,
    output logic      [IDX_W-1:0]              free_idx
);

    logic             hit_reg, hit_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // The first hit and the first free slot are kept, so the lowest index wins.
    always_comb
    begin
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        if (clear)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (cmp_en)
        begin
            if (valid_bit && (rd_key == key) && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx;
            end
            if (!valid_bit && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign hit      = hit_reg;
    assign hit_idx  = hit_idx_reg;
    assign free     = free_reg;
    assign free_idx = free_idx_reg;

endmodule

`default_nettype wire

// ===== rtl/skvt_checker.sv =====
// Port-level checker for the key/value table, bound to the top level.
`default_nettype none

module skvt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic        found,
    input wire logic [31:0] read_value
);

    // An accepted transaction keeps the table busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("table not busy after an accepted transaction");

    // A result only follows a busy period.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    // A present key always completes with status ok.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == skvt_pkg::STATUS_OK))
        else $error("found key reported with an error status");

    // A miss never returns data.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (read_value == 32'd0))
        else $error("nonzero read value on a miss");

    // Status never carries the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == skvt_pkg::STATUS_OK || status == skvt_pkg::STATUS_FULL
                  || status == skvt_pkg::STATUS_MISSING))
        else $error("undefined status code");

endmodule

bind small_key_value_table_core skvt_checker u_skvt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .found      (found),
    .read_value (read_value)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the key/value table core: random and directed traffic against a shadow table.
`timescale 1ns / 1ps

module tb;

    localparam int ENTRIES     = 16;
    localparam int VALUE_BITS  = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 50;

    // The package names three commands; the fourth code is still decoded by
    // the block and must leave the table untouched.
    localparam logic [1:0] CMD_UNDEF = 2'd3;

    // One result as the block reports it.
    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] read_value;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  cmd = skvt_pkg::CMD_GET;
    logic [31:0] key = '0;
    logic [31:0] value = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic        found;
    logic [31:0] read_value;

    // Shadow copy of the table, updated at the edge that accepts each transaction.
    logic [31:0] shadow_key [ENTRIES];
    logic [31:0] shadow_val [ENTRIES];
    logic        shadow_used [ENTRIES];

    // Results still owed by the block, oldest first.
    outcome_t pending_outcomes [$];

    // Keys that the current random phase draws from.
    logic [31:0] key_pool [$];

    int  cycle_count = 0;
    int  error_count = 0;
    int  checked_count = 0;
    int  accepted_count = 0;
    int  full_count = 0;
    int  missing_count = 0;
    int  get_hit_count = 0;
    bit  no_idle = 1'b0;

    small_key_value_table_core #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .key        (key),
        .value      (value),
        .done       (done),
        .status     (status),
        .found      (found),
        .read_value (read_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one command and applies it to the shadow table.
    // The lowest valid slot that matches wins, and a new key claims the lowest
    // free slot, so the shadow table stays slot for slot equal to the block.
    function automatic outcome_t predict_outcome(input logic [1:0] op, input logic [31:0] k,
                                                 input logic [31:0] v);
        outcome_t res;
        int       hit_slot;
        int       free_slot;
        hit_slot  = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (shadow_used[i] && shadow_key[i] == k && hit_slot < 0)
                hit_slot = i;
            if (!shadow_used[i] && free_slot < 0)
                free_slot = i;
        end
        res.found      = (hit_slot >= 0);
        res.status     = skvt_pkg::STATUS_OK;
        res.read_value = '0;
        case (op)
            skvt_pkg::CMD_SET:
            begin
                if (hit_slot >= 0)
                    shadow_val[hit_slot] = v;
                else if (free_slot >= 0)
                begin
                    shadow_used[free_slot] = 1'b1;
                    shadow_key[free_slot]  = k;
                    shadow_val[free_slot]  = v;
                end
                else
                    res.status = skvt_pkg::STATUS_FULL;
            end
            skvt_pkg::CMD_GET:
            begin
                if (hit_slot >= 0)
                    res.read_value = shadow_val[hit_slot];
                else
                    res.status = skvt_pkg::STATUS_MISSING;
            end
            skvt_pkg::CMD_REMOVE:
            begin
                if (hit_slot >= 0)
                    shadow_used[hit_slot] = 1'b0;
                else
                    res.status = skvt_pkg::STATUS_MISSING;
            end
            default:
            begin
                // The undefined command only reports presence.
                if (hit_slot < 0)
                    res.status = skvt_pkg::STATUS_MISSING;
            end
        endcase
        return res;
    endfunction

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("Mismatch at result %0d (cycle %0d): %s got 0x%0h, expected 0x%0h",
                     checked_count, cycle_count, what, got, want);
        error_count++;
    endtask

    // Monitor: everything is sampled at the rising edge, before the block's own
    // registers move, so inputs and outputs are seen as they stood during the
    // cycle that the edge closes. A result that is strobed at the same edge as
    // a new transaction is accepted always belongs to an older transaction.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("result with no transaction waiting, status",
                                    32'(status), 32'd0);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (found !== want.found)
                        report_mismatch("found", 32'(found), 32'(want.found));
                    if (read_value !== want.read_value)
                        report_mismatch("read_value", read_value, want.read_value);
                    if (want.status == skvt_pkg::STATUS_FULL)
                        full_count++;
                    if (want.status == skvt_pkg::STATUS_MISSING)
                        missing_count++;
                end
                checked_count++;
            end
            if (start && !busy)
            begin
                want = predict_outcome(cmd, key, value);
                if (cmd == skvt_pkg::CMD_GET && want.found)
                    get_hit_count++;
                pending_outcomes.push_back(want);
                accepted_count++;
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Presents one command and returns at the edge that accepts it. Start is
    // left high so that a following command can go out back to back; it is
    // lowered only when an idle gap is inserted or the stimulus ends.
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
        if (!no_idle && $urandom_range(0, 99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= op;
        key   <= k;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Values lean toward the extremes now and then.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // Builds a fresh key pool. Some keys differ from their neighbor in one bit
    // only, at a random position, to exercise the key compare on single bits.
    task automatic build_pool(input int size);
        logic [31:0] k;
        key_pool.delete();
        for (int i = 0; i < size; i++)
        begin
            if (i > 0 && $urandom_range(0, 3) == 0)
                k = key_pool[i - 1] ^ (32'h1 << $urandom_range(0, 31));
            else
                k = $urandom;
            key_pool.push_back(k);
        end
    endtask

    // Removes every pool key; keys drawn from outside the pool may stay in the table.
    task automatic drain_pool();
        foreach (key_pool[i])
            send_cmd(skvt_pkg::CMD_REMOVE, key_pool[i], $urandom);
    endtask

    // Random traffic over the current pool: mostly sets and gets, with removes
    // to free slots and a few undefined commands. A small share of keys comes
    // from outside the pool and almost always misses.
    task automatic pool_traffic(input int count);
        int          r;
        logic [1:0]  op;
        logic [31:0] k;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = skvt_pkg::CMD_SET;
            else if (r < 80)
                op = skvt_pkg::CMD_GET;
            else if (r < 95)
                op = skvt_pkg::CMD_REMOVE;
            else
                op = CMD_UNDEF;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                k = $urandom;
            send_cmd(op, k, pick_value());
        end
    endtask

    // Every command and the ok and missing statuses on the extreme keys and values, including
    // overwrite of a held key, a one-bit neighbor that must miss, a second
    // remove of the same key, reuse of a freed slot and the undefined command.
    task automatic test_directed();
        send_cmd(skvt_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(skvt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(CMD_UNDEF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(skvt_pkg::CMD_SET, 32'h0000_0000, 32'h0000_0000);
        send_cmd(skvt_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(skvt_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(skvt_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(skvt_pkg::CMD_SET, 32'h0000_0000, 32'hA5A5_A5A5);
        send_cmd(skvt_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(skvt_pkg::CMD_GET, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_cmd(skvt_pkg::CMD_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(skvt_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_cmd(skvt_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_cmd(skvt_pkg::CMD_SET, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
        send_cmd(skvt_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(skvt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(skvt_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fills every slot, overflows with two more keys, reads everything back
    // and empties the table again.
    task automatic test_fill_to_full();
        build_pool(ENTRIES + 2);
        foreach (key_pool[i])
            send_cmd(skvt_pkg::CMD_SET, key_pool[i], pick_value());
        foreach (key_pool[i])
            send_cmd(skvt_pkg::CMD_GET, key_pool[i], $urandom);
        drain_pool();
    endtask

    // Few keys in the pool: most gets hit.
    task automatic test_small_pool();
        build_pool(6);
        pool_traffic(300);
        drain_pool();
    endtask

    // More keys than slots, sent with no idle gaps: the table runs full often.
    task automatic test_crowded_pool();
        no_idle = 1'b1;
        build_pool(ENTRIES + 8);
        pool_traffic(450);
        drain_pool();
        no_idle = 1'b0;
    endtask

    // Many keys with idle gaps: a mix of hits, misses and full reports.
    task automatic test_sparse_pool();
        build_pool(40);
        pool_traffic(400);
        drain_pool();
    endtask

    initial
    begin
        foreach (shadow_used[i])
        begin
            shadow_used[i] = 1'b0;
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_to_full();
        test_small_pool();
        test_crowded_pool();
        test_sparse_pool();

        // The last command has been accepted; drop start and let the block
        // finish, then keep watching so that any stray result shows.
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        if (pending_outcomes.size() != 0)
            report_mismatch("results never delivered, count",
                            32'(pending_outcomes.size()), 32'd0);

        $display("Run covered %0d transactions and %0d results in %0d cycles.",
                 accepted_count, checked_count, cycle_count);
        $display("Get hits: %0d, full reports: %0d, key-missing reports: %0d, mismatches: %0d.",
                 get_hit_count, full_count, missing_count, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
